@@ hdl/date_difference_days_assert.svh @@
// Assertion macros used by the date difference RTL.
`ifndef DATE_DIFFERENCE_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define DD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dd_pkg.sv @@
// Widths, constants and calendar tables for the date difference block.
package dd_pkg;

  localparam int OP_W        = 2;
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int WDAY_W      = 3;
  localparam int DIFF_W      = 22;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  // Operation bits: each one marks a date given in nth-weekday form.
  localparam logic [OP_W-1:0] OP_SECOND_NTH = 2'b01;
  localparam logic [OP_W-1:0] OP_FIRST_NTH  = 2'b10;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [WDAY_W-1:0]  WDAY_MAX  = 3'd6;

  localparam logic [DIFF_W-1:0] DAYS_PER_YEAR = 22'd365;
  // Largest difference two existing dates can have (day 0 of January, year 1,
  // to 31 December, year 9999).
  localparam logic [DIFF_W-1:0] DIFF_LIMIT    = 22'd3652059;

  // floor(x / 100) = (x * RECIP_100) >> SHIFT_100 for every 14-bit x.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SHIFT_100 = 19;
  // floor(n / 7) = (n * RECIP_7) >> SHIFT_7 for every 22-bit n.
  localparam logic [22:0] RECIP_7   = 23'd4793491;
  localparam int          SHIFT_7   = 25;

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/date_difference_days.sv @@
// Top level: pipelined absolute day count between two Gregorian dates.
//
//  port group | dir | tdata fields (low bit up)                | tuser
//  -----------+-----+------------------------------------------+----------------
//  in_*       | in  | first_year, first_month, first_day,      | operation
//             |     | first_weekday, second_year, second_month,|
//             |     | second_day, second_weekday, 4 zero bits  |
//  out_*      | out | day_difference, 2 zero bits              | date_valid
//
//  One word per cycle unless the output stalls; stages 1 to 5 and the output
//  register lie on the path. The depth comes from the two constant multiplies
//  in each lane: divide-by-100 for the century terms and divide-by-7 for the
//  weekday of the first of the month, each followed by a register.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  A stall on the output side holds the last stage; empty stages upstream
//  keep filling, so in_tready drops only when all six stages hold a word.
module date_difference_days (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // first_year, first_month, first_day, first_weekday,
  // second_year, second_month, second_day, second_weekday, zero fill
  input  logic [dd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic [dd_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // day_difference, zero fill
  output logic [dd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // date_valid
  output logic [dd_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import dd_pkg::*;

  localparam int NSTG = 5;  // internal stages ahead of the output register

  // ---------------------------------------------------------------------------
  // Stall control: a stage advances when it is empty or the next one advances.
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld_r;
  logic [NSTG:1] adv;
  logic          out_adv;
  logic          out_vld_r;

  always_comb begin
    out_adv   = !out_vld_r || out_tready;
    adv[NSTG] = !vld_r[NSTG] || out_adv;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[1];

  // ---------------------------------------------------------------------------
  // Input unpack: lane 0 is the first date, lane 1 the second.
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0]  in_year  [2];
  logic [MONTH_W-1:0] in_month [2];
  logic [DAY_W-1:0]   in_day   [2];
  logic [WDAY_W-1:0]  in_wday  [2];
  logic               in_nth   [2];

  always_comb begin
    in_year[0]  = in_tdata[13:0];
    in_month[0] = in_tdata[17:14];
    in_day[0]   = in_tdata[22:18];
    in_wday[0]  = in_tdata[25:23];
    in_year[1]  = in_tdata[39:26];
    in_month[1] = in_tdata[43:40];
    in_day[1]   = in_tdata[48:44];
    in_wday[1]  = in_tdata[51:49];
    in_nth[0]   = |(in_tuser & OP_FIRST_NTH);
    in_nth[1]   = |(in_tuser & OP_SECOND_NTH);
  end

  // ---------------------------------------------------------------------------
  // Per-lane pipeline registers.
  // ---------------------------------------------------------------------------
  // stage 1: range check, years elapsed, century quotients
  logic [YEAR_W-1:0]  s1_year_r [2], s1_year_nxt [2];
  logic [YEAR_W-1:0]  s1_yrs_r  [2], s1_yrs_nxt  [2];
  logic [7:0]         s1_cp_r   [2], s1_cp_nxt   [2];
  logic [7:0]         s1_cy_r   [2], s1_cy_nxt   [2];
  logic [MONTH_W-1:0] s1_month_r[2];
  logic [DAY_W-1:0]   s1_day_r  [2];
  logic [WDAY_W-1:0]  s1_wday_r [2];
  logic               s1_nth_r  [2];
  logic               s1_ok_r   [2], s1_ok_nxt   [2];

  // stage 2: day number of the last day before the month, month length
  logic [DIFF_W-1:0]  s2_base_r [2], s2_base_nxt [2];
  logic [4:0]         s2_len_r  [2], s2_len_nxt  [2];
  logic [DAY_W-1:0]   s2_day_r  [2];
  logic [WDAY_W-1:0]  s2_wday_r [2];
  logic               s2_nth_r  [2];
  logic               s2_ok_r   [2];

  // stage 3: quotient of (base + 1) / 7
  logic [19:0]        s3_q7_r   [2], s3_q7_nxt   [2];
  logic [DIFF_W-1:0]  s3_base_r [2];
  logic [4:0]         s3_len_r  [2];
  logic [DAY_W-1:0]   s3_day_r  [2];
  logic [WDAY_W-1:0]  s3_wday_r [2];
  logic               s3_nth_r  [2];
  logic               s3_ok_r   [2];

  // stage 4: weekday of the first of the month
  logic [WDAY_W-1:0]  s4_fwd_r  [2], s4_fwd_nxt  [2];
  logic [DIFF_W-1:0]  s4_base_r [2];
  logic [4:0]         s4_len_r  [2];
  logic [DAY_W-1:0]   s4_day_r  [2];
  logic [WDAY_W-1:0]  s4_wday_r [2];
  logic               s4_nth_r  [2];
  logic               s4_ok_r   [2];

  // stage 5: resolved day number and existence flag
  logic [DIFF_W-1:0]  s5_num_r  [2], s5_num_nxt  [2];
  logic               s5_ok_r   [2], s5_ok_nxt   [2];

  // output register
  logic [DIFF_W-1:0]  out_diff_r, out_diff_nxt;
  logic               out_ok_r,   out_ok_nxt;

  // ---------------------------------------------------------------------------
  // Stage logic
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [26:0]        prod_p;
    logic [26:0]        prod_y;
    logic               leap;
    logic [14:0]        cent;
    logic [DIFF_W-1:0]  ydays;
    logic [DIFF_W-1:0]  np1;
    logic [44:0]        prod7;
    logic [DIFF_W-1:0]  rem;
    logic [3:0]         off;
    logic [7:0]         dom;
    logic               wday_bad;
    for (int i = 0; i < 2; i++) begin
      // stage 1
      s1_year_nxt[i] = in_year[i];
      s1_yrs_nxt[i]  = in_year[i] - 14'd1;
      prod_p         = 27'(s1_yrs_nxt[i]) * 27'(RECIP_100);
      prod_y         = 27'(in_year[i]) * 27'(RECIP_100);
      s1_cp_nxt[i]   = prod_p[SHIFT_100 +: 8];
      s1_cy_nxt[i]   = prod_y[SHIFT_100 +: 8];
      s1_ok_nxt[i]   = (in_year[i] != '0) && (in_year[i] <= YEAR_MAX) &&
                       (in_month[i] != '0) && (in_month[i] <= MONTH_DEC);

      // stage 2
      cent  = 15'(s1_cy_r[i]) * 15'd100;
      leap  = ((s1_year_r[i][1:0] == 2'b00) && (15'(s1_year_r[i]) != cent)) ||
              ((15'(s1_year_r[i]) == cent) && (s1_cy_r[i][1:0] == 2'b00));
      ydays = 22'(s1_yrs_r[i]) * DAYS_PER_YEAR + 22'(s1_yrs_r[i] >> 2)
              - 22'(s1_cp_r[i]) + 22'(s1_cp_r[i] >> 2);
      s2_base_nxt[i] = ydays + 22'(days_before(s1_month_r[i]))
                       + 22'((s1_month_r[i] > MONTH_FEB) && leap);
      s2_len_nxt[i]  = month_len(s1_month_r[i])
                       + 5'((s1_month_r[i] == MONTH_FEB) && leap);

      // stage 3: day 1 of year 1 is a Monday, so (base + 1) mod 7 is the
      // weekday of the first, Sunday being zero
      np1          = s2_base_r[i] + 22'd1;
      prod7        = 45'(np1) * 45'(RECIP_7);
      s3_q7_nxt[i] = prod7[SHIFT_7 +: 20];

      // stage 4
      rem           = (s3_base_r[i] + 22'd1) - 22'(s3_q7_r[i]) * 22'd7;
      s4_fwd_nxt[i] = rem[WDAY_W-1:0];

      // stage 5
      off = 4'(s4_wday_r[i]) + 4'd7 - 4'(s4_fwd_r[i]);
      if (off >= 4'd7) begin
        off = off - 4'd7;
      end
      wday_bad = 1'b0;
      if (!s4_nth_r[i]) begin
        dom = 8'(s4_day_r[i]);
      end else if (s4_day_r[i] == '0) begin
        // occurrence zero: last day of the previous month
        dom = 8'd0;
      end else begin
        dom      = 8'(off) + 8'd1 + (8'(s4_day_r[i]) - 8'd1) * 8'd7;
        wday_bad = s4_wday_r[i] > WDAY_MAX;
      end
      s5_num_nxt[i] = s4_base_r[i] + 22'(dom);
      s5_ok_nxt[i]  = s4_ok_r[i] && !wday_bad && (dom <= 8'(s4_len_r[i]));
    end

    // output: absolute difference, zero when either date does not exist
    out_ok_nxt = s5_ok_r[0] && s5_ok_r[1];
    if (!out_ok_nxt) begin
      out_diff_nxt = '0;
    end else if (s5_num_r[0] > s5_num_r[1]) begin
      out_diff_nxt = s5_num_r[0] - s5_num_r[1];
    end else begin
      out_diff_nxt = s5_num_r[1] - s5_num_r[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (out_adv) begin
        out_vld_r <= vld_r[NSTG];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (adv[1]) begin
        s1_year_r[i]  <= s1_year_nxt[i];
        s1_yrs_r[i]   <= s1_yrs_nxt[i];
        s1_cp_r[i]    <= s1_cp_nxt[i];
        s1_cy_r[i]    <= s1_cy_nxt[i];
        s1_month_r[i] <= in_month[i];
        s1_day_r[i]   <= in_day[i];
        s1_wday_r[i]  <= in_wday[i];
        s1_nth_r[i]   <= in_nth[i];
        s1_ok_r[i]    <= s1_ok_nxt[i];
      end
      if (adv[2]) begin
        s2_base_r[i] <= s2_base_nxt[i];
        s2_len_r[i]  <= s2_len_nxt[i];
        s2_day_r[i]  <= s1_day_r[i];
        s2_wday_r[i] <= s1_wday_r[i];
        s2_nth_r[i]  <= s1_nth_r[i];
        s2_ok_r[i]   <= s1_ok_r[i];
      end
      if (adv[3]) begin
        s3_q7_r[i]   <= s3_q7_nxt[i];
        s3_base_r[i] <= s2_base_r[i];
        s3_len_r[i]  <= s2_len_r[i];
        s3_day_r[i]  <= s2_day_r[i];
        s3_wday_r[i] <= s2_wday_r[i];
        s3_nth_r[i]  <= s2_nth_r[i];
        s3_ok_r[i]   <= s2_ok_r[i];
      end
      if (adv[4]) begin
        s4_fwd_r[i]  <= s4_fwd_nxt[i];
        s4_base_r[i] <= s3_base_r[i];
        s4_len_r[i]  <= s3_len_r[i];
        s4_day_r[i]  <= s3_day_r[i];
        s4_wday_r[i] <= s3_wday_r[i];
        s4_nth_r[i]  <= s3_nth_r[i];
        s4_ok_r[i]   <= s3_ok_r[i];
      end
      if (adv[5]) begin
        s5_num_r[i] <= s5_num_nxt[i];
        s5_ok_r[i]  <= s5_ok_nxt[i];
      end
    end
    if (out_adv) begin
      out_diff_r <= out_diff_nxt;
      out_ok_r   <= out_ok_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_diff_r};
  assign out_tuser  = out_ok_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "date_difference_days_assert.svh"

  `DD_ASSERT_SAME(a_invalid_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "invalid word carries a nonzero difference")
  `DD_ASSERT_SAME(a_diff_bound, out_tvalid && out_tuser[0], out_diff_r <= DIFF_LIMIT, "difference beyond any pair of existing dates")
  `DD_ASSERT_SAME(a_ready_full, !in_tready, (&vld_r) && out_tvalid && !out_tready, "input held off while a stage is empty")
  `DD_ASSERT_SAME(a_wday_lane0, vld_r[4], s4_fwd_r[0] <= WDAY_MAX, "first date weekday remainder out of range")
  `DD_ASSERT_SAME(a_wday_lane1, vld_r[4], s4_fwd_r[1] <= WDAY_MAX, "second date weekday remainder out of range")

endmodule
